[hdl/sit_pkg.sv]
`timescale 1ns / 1ps

package sit_pkg;

    localparam int COORD_WIDTH = 16;   // 4..16 (no wider than FIELD_W)
    localparam int FIELD_W     = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } vec_t;

    // sign of a cross or dot term
    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

    // advance strobes for the product and sign stages
    typedef struct packed {
        logic prod;
        logic sgn;
    } stage_en_t;

    // low COORD_WIDTH bits of a field, sign-extended by one bit
    function automatic diff_t ext_coord(field_t f);
        diff_t r;
        r = '0;
        for (int i = 0; i < COORD_WIDTH && i < FIELD_W; i++)
        begin
            r[i] = f[i];
        end
        r[DIFF_W-1] = r[COORD_WIDTH-1];
        return r;
    endfunction

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        return r;
    endfunction

endpackage

[hdl/sit_term.sv]
`timescale 1ns / 1ps

// m0a*m0b -/+ m1a*m1b, reduced to its sign; two register stages
module sit_term (
    input  logic                clk,
    input  sit_pkg::stage_en_t  en,
    input  sit_pkg::diff_t      m0a,
    input  sit_pkg::diff_t      m0b,
    input  sit_pkg::diff_t      m1a,
    input  sit_pkg::diff_t      m1b,
    input  logic                sub,
    output sit_pkg::sign_t      sgn
);

    sit_pkg::prod_t p0_reg, p0_next;
    sit_pkg::prod_t p1_reg, p1_next;
    logic           sub_reg;
    sit_pkg::prod_t sum;
    sit_pkg::sign_t sgn_reg, sgn_next;

    always_comb
    begin
        p0_next = m0a * m0b;
        p1_next = m1a * m1b;
    end

    // magnitudes stay below 2^(2*COORD_WIDTH+1), so no extra bit needed
    always_comb
    begin
        sum           = sub_reg ? (p0_reg - p1_reg) : (p0_reg + p1_reg);
        sgn_next.neg  = sum[sit_pkg::PROD_W-1];
        sgn_next.zero = (sum == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            sub_reg <= sub;
        end
        if (en.sgn)
        begin
            sgn_reg <= sgn_next;
        end
    end

    assign sgn = sgn_reg;

endmodule

[hdl/segment_intersection_test.sv]
`timescale 1ns / 1ps

// Exact 2D segment intersection test. Each input beat carries segments
// A = (a1, a2) and B = (b1, b2); each output beat carries touches (shared
// point, endpoints included), crosses_properly (crossing interior to both)
// and parallel_dirs (direction cross product is zero). Coordinates are the
// low sit_pkg::COORD_WIDTH bits of each field, two's complement. The block
// is a four-stage pipeline: endpoint differences, 18 parallel multipliers,
// cross/dot sums reduced to signs, then the flag register. A beat goes
// through the difference, product and sign registers before out_valid
// rises, and one beat is taken every cycle; each stage holds under
// backpressure and empty stages keep accepting while the output waits.
module segment_intersection_test (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::field_t a1_x,
    input  sit_pkg::field_t a1_y,
    input  sit_pkg::field_t a2_x,
    input  sit_pkg::field_t a2_y,
    input  sit_pkg::field_t b1_x,
    input  sit_pkg::field_t b1_y,
    input  sit_pkg::field_t b2_x,
    input  sit_pkg::field_t b2_y,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            touches,
    output logic            crosses_properly,
    output logic            parallel_dirs
);

    sit_pkg::vec_t p_a1, p_a2, p_b1, p_b2;

    // stage 1: difference vectors
    sit_pkg::vec_t v_reg, v_next;          // a2 - a1
    sit_pkg::vec_t w_reg, w_next;          // b2 - b1
    sit_pkg::vec_t ba1_reg, ba1_next;      // b1 - a1
    sit_pkg::vec_t b2a1_reg, b2a1_next;    // b2 - a1
    sit_pkg::vec_t a1b1_reg, a1b1_next;    // a1 - b1
    sit_pkg::vec_t a2b1_reg, a2b1_next;    // a2 - b1
    sit_pkg::vec_t b1a2_reg, b1a2_next;    // b1 - a2
    sit_pkg::vec_t b2a2_reg, b2a2_next;    // b2 - a2
    sit_pkg::vec_t a1b2_reg, a1b2_next;    // a1 - b2
    sit_pkg::vec_t a2b2_reg, a2b2_next;    // a2 - b2

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy_o;
    sit_pkg::stage_en_t en;

    sit_pkg::sign_t c1, c2, c3, c4, c5;
    sit_pkg::sign_t d0, d1, d2, d3;

    logic pos1, pos2, pos3, pos4;
    logic touches_reg, touches_next;
    logic crosses_reg, crosses_next;
    logic parallel_reg, parallel_next;
    logic touch_par, touch_gen;

    // handshake: a stage moves when it is empty or the next one moves
    assign rdy_o   = !out_valid_reg || out_ready;
    assign rdy3    = !v3_reg || rdy_o;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign en.prod = rdy2 && v1_reg;
    assign en.sgn  = rdy3 && v2_reg;

    always_comb
    begin
        p_a1.x = sit_pkg::ext_coord(a1_x);
        p_a1.y = sit_pkg::ext_coord(a1_y);
        p_a2.x = sit_pkg::ext_coord(a2_x);
        p_a2.y = sit_pkg::ext_coord(a2_y);
        p_b1.x = sit_pkg::ext_coord(b1_x);
        p_b1.y = sit_pkg::ext_coord(b1_y);
        p_b2.x = sit_pkg::ext_coord(b2_x);
        p_b2.y = sit_pkg::ext_coord(b2_y);

        v_next    = sit_pkg::vsub(p_a2, p_a1);
        w_next    = sit_pkg::vsub(p_b2, p_b1);
        ba1_next  = sit_pkg::vsub(p_b1, p_a1);
        b2a1_next = sit_pkg::vsub(p_b2, p_a1);
        a1b1_next = sit_pkg::vsub(p_a1, p_b1);
        a2b1_next = sit_pkg::vsub(p_a2, p_b1);
        b1a2_next = sit_pkg::vsub(p_b1, p_a2);
        b2a2_next = sit_pkg::vsub(p_b2, p_a2);
        a1b2_next = sit_pkg::vsub(p_a1, p_b2);
        a2b2_next = sit_pkg::vsub(p_a2, p_b2);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            v_reg    <= v_next;
            w_reg    <= w_next;
            ba1_reg  <= ba1_next;
            b2a1_reg <= b2a1_next;
            a1b1_reg <= a1b1_next;
            a2b1_reg <= a2b1_next;
            b1a2_reg <= b1a2_next;
            b2a2_reg <= b2a2_next;
            a1b2_reg <= a1b2_next;
            a2b2_reg <= a2b2_next;
        end
    end

    // orientation crosses: c1/c2 = B endpoints vs line A, c3/c4 = A vs line B
    sit_term u_c1 (.clk(clk), .en(en), .m0a(v_reg.x), .m0b(ba1_reg.y),
                   .m1a(v_reg.y), .m1b(ba1_reg.x), .sub(1'b1), .sgn(c1));
    sit_term u_c2 (.clk(clk), .en(en), .m0a(v_reg.x), .m0b(b2a1_reg.y),
                   .m1a(v_reg.y), .m1b(b2a1_reg.x), .sub(1'b1), .sgn(c2));
    sit_term u_c3 (.clk(clk), .en(en), .m0a(w_reg.x), .m0b(a1b1_reg.y),
                   .m1a(w_reg.y), .m1b(a1b1_reg.x), .sub(1'b1), .sgn(c3));
    sit_term u_c4 (.clk(clk), .en(en), .m0a(w_reg.x), .m0b(a2b1_reg.y),
                   .m1a(w_reg.y), .m1b(a2b1_reg.x), .sub(1'b1), .sgn(c4));
    sit_term u_c5 (.clk(clk), .en(en), .m0a(v_reg.x), .m0b(w_reg.y),
                   .m1a(v_reg.y), .m1b(w_reg.x), .sub(1'b1), .sgn(c5));

    // endpoint-on-segment dots
    sit_term u_d0 (.clk(clk), .en(en), .m0a(ba1_reg.x), .m0b(b2a1_reg.x),
                   .m1a(ba1_reg.y), .m1b(b2a1_reg.y), .sub(1'b0), .sgn(d0));
    sit_term u_d1 (.clk(clk), .en(en), .m0a(b1a2_reg.x), .m0b(b2a2_reg.x),
                   .m1a(b1a2_reg.y), .m1b(b2a2_reg.y), .sub(1'b0), .sgn(d1));
    sit_term u_d2 (.clk(clk), .en(en), .m0a(a1b1_reg.x), .m0b(a2b1_reg.x),
                   .m1a(a1b1_reg.y), .m1b(a2b1_reg.y), .sub(1'b0), .sgn(d2));
    sit_term u_d3 (.clk(clk), .en(en), .m0a(a1b2_reg.x), .m0b(a2b2_reg.x),
                   .m1a(a1b2_reg.y), .m1b(a2b2_reg.y), .sub(1'b0), .sgn(d3));

    // on-segment crosses reuse the orientation terms:
    // cross(b1-a1, b2-a1) = c3, cross(b1-a2, b2-a2) = c4,
    // cross(a1-b1, a2-b1) = c1, cross(a1-b2, a2-b2) = c2
    always_comb
    begin
        pos1 = !c1.neg && !c1.zero;
        pos2 = !c2.neg && !c2.zero;
        pos3 = !c3.neg && !c3.zero;
        pos4 = !c4.neg && !c4.zero;

        touch_par = (c3.zero && (d0.neg || d0.zero)) ||
                    (c4.zero && (d1.neg || d1.zero)) ||
                    (c1.zero && (d2.neg || d2.zero)) ||
                    (c2.zero && (d3.neg || d3.zero));
        touch_gen = !((pos1 && pos2) || (c1.neg && c2.neg)) &&
                    !((pos3 && pos4) || (c3.neg && c4.neg));

        parallel_next = c5.zero;
        crosses_next  = ((pos1 && c2.neg) || (c1.neg && pos2)) &&
                        ((pos3 && c4.neg) || (c3.neg && pos4));
        touches_next  = c5.zero ? touch_par : touch_gen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_o)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o && v3_reg)
        begin
            touches_reg  <= touches_next;
            crosses_reg  <= crosses_next;
            parallel_reg <= parallel_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign touches          = touches_reg;
    assign crosses_properly = crosses_reg;
    assign parallel_dirs    = parallel_reg;

endmodule
